// ===== rtl/tgr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and reset constants for the touch gesture recognizer.
// No dependencies; every other file in rtl/ uses this package.
package tgr_pkg;

    localparam int COORD_W  = 11;
    localparam int TIME_W   = 32;
    localparam int RAW_W    = 16;
    localparam int TS_W     = 32;
    localparam int SIZE_W   = 12;
    localparam int MS_W     = 16;
    localparam int DIST_W   = 11;
    localparam int CFG_DW   = 16;
    localparam int CFG_IW   = 3;

    localparam int MS_TO_US = 1000;
    localparam int US_W     = MS_W + 10;
    localparam int DSQ_CFG_W = 2 * DIST_W;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int DSQ_W    = (2 * COORD_W + 1 > DSQ_CFG_W) ? 2 * COORD_W + 1 : DSQ_CFG_W;
    localparam int TCMP_W   = (TIME_W > US_W) ? TIME_W : US_W;
    localparam int CLAMP_W  = (RAW_W > COORD_W) ? RAW_W : COORD_W;
    localparam int LIM_W    = (SIZE_W > COORD_W + 1) ? SIZE_W : COORD_W + 1;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = Q_PTR_W + 1;

    localparam int WIDTH_RST     = 540;
    localparam int HEIGHT_RST    = 960;
    localparam int LONG_MS_RST   = 500;
    localparam int LONG_DIST_RST = 20;
    localparam int SWIPE_RST     = 50;
    localparam int TAP_DIST_RST  = 20;
    localparam int TAP_MS_RST    = 300;
    localparam int COORD_CAP     = 1 << COORD_W;

    localparam logic [LIM_W-1:0] COORD_CAP_L = LIM_W'(COORD_CAP);
    localparam logic [COORD_W-1:0] X_MAX_RST =
        COORD_W'(((WIDTH_RST > COORD_CAP) ? COORD_CAP : WIDTH_RST) - 1);
    localparam logic [COORD_W-1:0] Y_MAX_RST =
        COORD_W'(((HEIGHT_RST > COORD_CAP) ? COORD_CAP : HEIGHT_RST) - 1);
    localparam logic [US_W-1:0] LONG_US_RST = US_W'(LONG_MS_RST * MS_TO_US);
    localparam logic [US_W-1:0] TAP_US_RST  = US_W'(TAP_MS_RST * MS_TO_US);
    localparam logic [DSQ_CFG_W-1:0] LONG_DSQ_RST  = DSQ_CFG_W'(LONG_DIST_RST * LONG_DIST_RST);
    localparam logic [DSQ_CFG_W-1:0] SWIPE_DSQ_RST = DSQ_CFG_W'(SWIPE_RST * SWIPE_RST);
    localparam logic [DSQ_CFG_W-1:0] TAP_DSQ_RST   = DSQ_CFG_W'(TAP_DIST_RST * TAP_DIST_RST);

    typedef enum logic [CFG_IW-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_LONG_PRESS_MS = 3'd2,
        CFG_LONG_PRESS_DIST = 3'd3,
        CFG_SWIPE_MIN_DIST = 3'd4,
        CFG_TAP_MAX_DIST  = 3'd5,
        CFG_TAP_MAX_TIME  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        EV_DOWN  = 3'd0,
        EV_MOVE  = 3'd1,
        EV_UP    = 3'd2,
        EV_LONG  = 3'd3,
        EV_TAP   = 3'd4,
        EV_SWIPE = 3'd5
    } t_event_kind;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRACK = 2'd1,
        PH_LONG  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } t_swipe_dir;

    typedef struct packed {
        logic                    sample_valid;
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic [TS_W-1:0]         timestamp_us;
    } t_sample;

    typedef struct packed {
        t_event_kind         event_kind;
        logic [COORD_W-1:0]  point_x;
        logic [COORD_W-1:0]  point_y;
        logic [COORD_W-1:0]  origin_x;
        logic [COORD_W-1:0]  origin_y;
        t_swipe_dir          swipe_dir;
        logic                last_of_run;
    } t_result;

    // thresholds in the form the datapath compares against
    typedef struct packed {
        logic [COORD_W-1:0]   x_max;
        logic [COORD_W-1:0]   y_max;
        logic [US_W-1:0]      long_us;
        logic [DSQ_CFG_W-1:0] long_dsq;
        logic [DSQ_CFG_W-1:0] swipe_dsq;
        logic [DSQ_CFG_W-1:0] tap_dsq;
        logic [US_W-1:0]      tap_us;
    } t_cfg;

    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// ===== rtl/tgr_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration registers; stores the derived clamp limits, squared distances
// and microsecond bounds. Depends on tgr_pkg.
module tgr_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tgr_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [tgr_pkg::CFG_DW-1:0]  i_cfg_data,
    output tgr_pkg::t_cfg               o_cfg
);

    tgr_pkg::t_cfg r_cfg;
    tgr_pkg::t_cfg n_cfg;

    logic [tgr_pkg::LIM_W-1:0]     size_lim;
    logic [tgr_pkg::COORD_W-1:0]   size_max;
    logic [tgr_pkg::US_W-1:0]      ms_us;
    logic [tgr_pkg::DSQ_CFG_W-1:0] dist_sq;

    always_comb begin
        size_lim = tgr_pkg::LIM_W'(i_cfg_data[tgr_pkg::SIZE_W-1:0]);
        if (size_lim == '0) begin
            size_lim = tgr_pkg::LIM_W'(1);
        end
        if (size_lim > tgr_pkg::COORD_CAP_L) begin
            size_lim = tgr_pkg::COORD_CAP_L;
        end
        size_max = tgr_pkg::COORD_W'(size_lim - tgr_pkg::LIM_W'(1));
        ms_us = tgr_pkg::US_W'(i_cfg_data[tgr_pkg::MS_W-1:0])
              * tgr_pkg::US_W'(tgr_pkg::MS_TO_US);
        dist_sq = tgr_pkg::DSQ_CFG_W'(i_cfg_data[tgr_pkg::DIST_W-1:0])
                * tgr_pkg::DSQ_CFG_W'(i_cfg_data[tgr_pkg::DIST_W-1:0]);
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                tgr_pkg::CFG_SCREEN_WIDTH:    n_cfg.x_max = size_max;
                tgr_pkg::CFG_SCREEN_HEIGHT:   n_cfg.y_max = size_max;
                tgr_pkg::CFG_LONG_PRESS_MS:   n_cfg.long_us = ms_us;
                tgr_pkg::CFG_LONG_PRESS_DIST: n_cfg.long_dsq = dist_sq;
                tgr_pkg::CFG_SWIPE_MIN_DIST:  n_cfg.swipe_dsq = dist_sq;
                tgr_pkg::CFG_TAP_MAX_DIST:    n_cfg.tap_dsq = dist_sq;
                tgr_pkg::CFG_TAP_MAX_TIME:    n_cfg.tap_us = ms_us;
                default:                      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_max     <= tgr_pkg::X_MAX_RST;
            r_cfg.y_max     <= tgr_pkg::Y_MAX_RST;
            r_cfg.long_us   <= tgr_pkg::LONG_US_RST;
            r_cfg.long_dsq  <= tgr_pkg::LONG_DSQ_RST;
            r_cfg.swipe_dsq <= tgr_pkg::SWIPE_DSQ_RST;
            r_cfg.tap_dsq   <= tgr_pkg::TAP_DSQ_RST;
            r_cfg.tap_us    <= tgr_pkg::TAP_US_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/tgr_core.sv =====
`timescale 1ns / 1ps
// Gesture state and per-sample event decode: clamp, distance, timing checks.
// Depends on tgr_pkg; fed by the input register and the configuration block.
module tgr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  tgr_pkg::t_sample i_sample,
    input  tgr_pkg::t_cfg    i_cfg,
    output tgr_pkg::t_push   o_push
);

    logic                        r_was_pressed;
    tgr_pkg::t_phase             r_phase;
    logic [tgr_pkg::COORD_W-1:0] r_start_x;
    logic [tgr_pkg::COORD_W-1:0] r_start_y;
    logic [tgr_pkg::COORD_W-1:0] r_cur_x;
    logic [tgr_pkg::COORD_W-1:0] r_cur_y;
    logic [tgr_pkg::TIME_W-1:0]  r_start_time;

    logic                        n_was_pressed;
    tgr_pkg::t_phase             n_phase;
    logic [tgr_pkg::COORD_W-1:0] n_start_x;
    logic [tgr_pkg::COORD_W-1:0] n_start_y;
    logic [tgr_pkg::COORD_W-1:0] n_cur_x;
    logic [tgr_pkg::COORD_W-1:0] n_cur_y;
    logic [tgr_pkg::TIME_W-1:0]  n_start_time;

    logic [tgr_pkg::COORD_W-1:0] x;
    logic [tgr_pkg::COORD_W-1:0] y;
    logic [tgr_pkg::COORD_W-1:0] px;
    logic [tgr_pkg::COORD_W-1:0] py;
    logic signed [tgr_pkg::COORD_W:0] dx;
    logic signed [tgr_pkg::COORD_W:0] dy;
    logic [tgr_pkg::COORD_W-1:0] ax;
    logic [tgr_pkg::COORD_W-1:0] ay;
    logic [tgr_pkg::SQ_W-1:0]    sqx;
    logic [tgr_pkg::SQ_W-1:0]    sqy;
    logic [tgr_pkg::DSQ_W-1:0]   dsq;
    logic [tgr_pkg::TIME_W-1:0]  now;
    logic [tgr_pkg::TIME_W-1:0]  elapsed;
    logic                        long_hit;
    logic                        swipe_hit;
    logic                        tap_hit;
    tgr_pkg::t_swipe_dir         dir;
    tgr_pkg::t_result            res_a;
    tgr_pkg::t_result            res_b;
    logic [1:0]                  num;

    function automatic logic [tgr_pkg::COORD_W-1:0] clamp_coord(
        input logic signed [tgr_pkg::RAW_W-1:0] raw,
        input logic [tgr_pkg::COORD_W-1:0]      hi
    );
        logic [tgr_pkg::CLAMP_W-1:0] mag;
        mag = tgr_pkg::CLAMP_W'($unsigned(raw));
        if (raw < 0) begin
            clamp_coord = '0;
        end else if (mag > tgr_pkg::CLAMP_W'(hi)) begin
            clamp_coord = hi;
        end else begin
            clamp_coord = tgr_pkg::COORD_W'(mag);
        end
    endfunction

    function automatic tgr_pkg::t_result make_result(
        input tgr_pkg::t_event_kind          kind,
        input logic [tgr_pkg::COORD_W-1:0]   pt_x,
        input logic [tgr_pkg::COORD_W-1:0]   pt_y,
        input logic [tgr_pkg::COORD_W-1:0]   or_x,
        input logic [tgr_pkg::COORD_W-1:0]   or_y,
        input tgr_pkg::t_swipe_dir           sdir
    );
        tgr_pkg::t_result r;
        r.event_kind  = kind;
        r.point_x     = pt_x;
        r.point_y     = pt_y;
        r.origin_x    = or_x;
        r.origin_y    = or_y;
        r.swipe_dir   = sdir;
        r.last_of_run = 1'b0;
        make_result = r;
    endfunction

    // distance datapath, shared by the move and release cases
    always_comb begin
        x = clamp_coord(i_sample.raw_x, i_cfg.x_max);
        y = clamp_coord(i_sample.raw_y, i_cfg.y_max);
        px = i_sample.sample_valid ? x : r_cur_x;
        py = i_sample.sample_valid ? y : r_cur_y;
        dx = $signed({1'b0, px}) - $signed({1'b0, r_start_x});
        dy = $signed({1'b0, py}) - $signed({1'b0, r_start_y});
        ax = dx[tgr_pkg::COORD_W] ? tgr_pkg::COORD_W'(-dx) : tgr_pkg::COORD_W'(dx);
        ay = dy[tgr_pkg::COORD_W] ? tgr_pkg::COORD_W'(-dy) : tgr_pkg::COORD_W'(dy);
        sqx = tgr_pkg::SQ_W'(ax) * tgr_pkg::SQ_W'(ax);
        sqy = tgr_pkg::SQ_W'(ay) * tgr_pkg::SQ_W'(ay);
        dsq = tgr_pkg::DSQ_W'(sqx) + tgr_pkg::DSQ_W'(sqy);
        now = tgr_pkg::TIME_W'(i_sample.timestamp_us);
        elapsed = now - r_start_time;
        long_hit = (tgr_pkg::TCMP_W'(elapsed) >= tgr_pkg::TCMP_W'(i_cfg.long_us))
                && (dsq < tgr_pkg::DSQ_W'(i_cfg.long_dsq));
        swipe_hit = dsq >= tgr_pkg::DSQ_W'(i_cfg.swipe_dsq);
        tap_hit = (dsq < tgr_pkg::DSQ_W'(i_cfg.tap_dsq))
               && (tgr_pkg::TCMP_W'(elapsed) < tgr_pkg::TCMP_W'(i_cfg.tap_us));
        if (ax >= ay) begin
            dir = dx[tgr_pkg::COORD_W] ? tgr_pkg::DIR_LEFT : tgr_pkg::DIR_RIGHT;
        end else begin
            dir = dy[tgr_pkg::COORD_W] ? tgr_pkg::DIR_UP : tgr_pkg::DIR_DOWN;
        end
    end

    always_comb begin
        n_was_pressed = r_was_pressed;
        n_phase       = r_phase;
        n_start_x     = r_start_x;
        n_start_y     = r_start_y;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_start_time  = r_start_time;
        num   = 2'd0;
        res_a = make_result(tgr_pkg::EV_DOWN, x, y, x, y, tgr_pkg::DIR_LEFT);
        res_b = make_result(tgr_pkg::EV_LONG, r_start_x, r_start_y,
                            r_start_x, r_start_y, tgr_pkg::DIR_LEFT);
        if (i_sample.sample_valid) begin
            n_was_pressed = 1'b1;
            n_cur_x = x;
            n_cur_y = y;
            num = 2'd1;
            if (!r_was_pressed) begin
                n_phase      = tgr_pkg::PH_TRACK;
                n_start_x    = x;
                n_start_y    = y;
                n_start_time = now;
            end else begin
                res_a = make_result(tgr_pkg::EV_MOVE, x, y, r_start_x, r_start_y,
                                    tgr_pkg::DIR_LEFT);
                if (r_phase == tgr_pkg::PH_TRACK && long_hit) begin
                    num     = 2'd2;
                    n_phase = tgr_pkg::PH_LONG;
                end
            end
        end else if (r_was_pressed) begin
            n_was_pressed = 1'b0;
            n_phase = tgr_pkg::PH_IDLE;
            num = 2'd1;
            res_a = make_result(tgr_pkg::EV_UP, r_cur_x, r_cur_y, r_start_x, r_start_y,
                                tgr_pkg::DIR_LEFT);
            if (r_phase == tgr_pkg::PH_TRACK) begin
                if (swipe_hit) begin
                    num = 2'd2;
                    res_b = make_result(tgr_pkg::EV_SWIPE, '0, '0, '0, '0, dir);
                end else if (tap_hit) begin
                    num = 2'd2;
                    res_b = make_result(tgr_pkg::EV_TAP, r_start_x, r_start_y,
                                        r_start_x, r_start_y, tgr_pkg::DIR_LEFT);
                end
            end
        end
        res_a.last_of_run = (num == 2'd1);
        res_b.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_pressed <= 1'b0;
            r_phase       <= tgr_pkg::PH_IDLE;
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_start_time  <= '0;
        end else if (i_fire) begin
            r_was_pressed <= n_was_pressed;
            r_phase       <= n_phase;
            r_start_x     <= n_start_x;
            r_start_y     <= n_start_y;
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_start_time  <= n_start_time;
        end
    end

    assign o_push.num    = i_fire ? num : 2'd0;
    assign o_push.first  = res_a;
    assign o_push.second = res_b;

endmodule

// ===== rtl/tgr_out_queue.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two results a cycle, hands out one a cycle when popped.
// Depends on tgr_pkg.
module tgr_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tgr_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_valid,
    output tgr_pkg::t_result o_data,
    output logic             o_room
);

    tgr_pkg::t_result            r_mem [tgr_pkg::Q_DEPTH];
    logic [tgr_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [tgr_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [tgr_pkg::Q_CNT_W-1:0] r_count;

    logic [tgr_pkg::Q_PTR_W-1:0] n_wr_ptr;
    logic [tgr_pkg::Q_PTR_W-1:0] n_rd_ptr;
    logic [tgr_pkg::Q_CNT_W-1:0] n_count;
    logic [tgr_pkg::Q_PTR_W-1:0] wr_ptr_1;

    always_comb begin
        wr_ptr_1 = r_wr_ptr + tgr_pkg::Q_PTR_W'(1);
        n_wr_ptr = r_wr_ptr + tgr_pkg::Q_PTR_W'(i_push.num);
        n_rd_ptr = i_pop ? r_rd_ptr + tgr_pkg::Q_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + tgr_pkg::Q_CNT_W'(i_push.num)
                 - tgr_pkg::Q_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_room  = r_count <= tgr_pkg::Q_CNT_W'(tgr_pkg::Q_DEPTH - 2);

endmodule

// ===== rtl/touch_gesture_recognizer.sv =====
`timescale 1ns / 1ps
// Top level of the touch gesture recognizer: input register, configuration,
// gesture core and result queue. Depends on tgr_pkg and the tgr_* modules.
//
// Each request on the input channel is one polled touch sample; it yields zero,
// one or two gesture events (down, move, up, long press, tap, swipe) in order,
// the last of them flagged by last_of_run. A sample is held in an input
// register and decoded once the four-entry result queue has room for two
// more events; events leave the queue one per cycle while the output is not
// stalled. The input register takes a new sample while the last one is
// decoded, the single output port setting the pace; the first event of a
// sample is offered once it has passed the input register and the queue.
// Configuration writes take effect at once and are meant to be made while no
// sample is in flight. There is no initialization sweep after reset.
module touch_gesture_recognizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  tgr_pkg::t_sample            i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output tgr_pkg::t_result            o_out_data,
    input  logic                        i_cfg_we,
    input  logic [tgr_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [tgr_pkg::CFG_DW-1:0]  i_cfg_data
);

    logic             r_in_valid;
    tgr_pkg::t_sample r_in;
    logic             n_in_valid;

    tgr_pkg::t_cfg    cfg;
    tgr_pkg::t_push   push;
    logic             room;
    logic             take;
    logic             accept;
    logic             pop;

    assign take       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign accept     = i_in_valid && !o_in_stall;
    assign pop        = o_out_valid && !i_out_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (take) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    tgr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tgr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (take),
        .i_sample (r_in),
        .i_cfg    (cfg),
        .o_push   (push)
    );

    tgr_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_room  (room)
    );

endmodule
